// File: hw/rtl/ltcw_pkg.sv
// ----------------------------------------------------------------------------
// ltcw_pkg
// Shared widths, codes and controller/datapath interface types for the
// load cell tare and calibration weigher.
// ----------------------------------------------------------------------------
package ltcw_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;

  localparam int KW_BITS       = 16;
  localparam int CNT_BITS      = 8;
  localparam int RES_BITS      = 32;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = KW_BITS;

  // running sum of up to 255 samples never wraps
  localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  // magnitude times 100 stays below 2^(DIFF_BITS + 7)
  localparam int NUM_BITS  = DIFF_BITS + 7;
  localparam int DVD_BITS  = NUM_BITS + FRACTION_BITS;
  localparam int DEN_BITS  = RES_BITS;
  localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * RES_BITS + SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [NUM_BITS-1:0] CENTI_SCALE = NUM_BITS'(100);

  localparam logic [RES_BITS-1:0] FACTOR_RESET =
    RES_BITS'((64'd7417 << FRACTION_BITS) / 64'd100);
  localparam logic [KW_BITS-1:0]  KNOWN_WEIGHT_RESET = KW_BITS'(796);
  localparam logic [CNT_BITS-1:0] AVG_COUNT_RESET    = CNT_BITS'(20);

  localparam logic [DVD_BITS-1:0] SAT_POS = DVD_BITS'((64'd1 << (RES_BITS - 1)) - 64'd1);
  localparam logic [DVD_BITS-1:0] SAT_NEG = DVD_BITS'(64'd1 << (RES_BITS - 1));

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_KNOWN_WEIGHT = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_AVG_COUNT    = 1'd1;

  // opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TARE   = 2'd1;
  localparam logic [1:0] OP_CAL    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_TARE   = 2'd1;
  localparam logic [1:0] KIND_CAL    = 2'd2;
  localparam logic [1:0] KIND_ZERO   = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TARE = 2'd1,
    MODE_CAL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIV_AVG = 2'd0,
    DIV_CAL = 2'd1,
    DIV_WGT = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_AVG_GO,
    S_AVG_WAIT,
    S_CAL_GO,
    S_CAL_WAIT,
    S_MUL,
    S_WGT_GO,
    S_WGT_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       start_avg;
    logic       accumulate;
    logic       clear_avg;
    logic       div_start;
    div_sel_t   div_sel;
    logic       mul;
    logic       load_offset;
    logic       load_avg;
    logic       load_factor;
    logic       load_weight;
    logic       set_kind;
    logic [1:0] kind;
    logic       out_load;
  } ltcw_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       missing;
    mode_t      mode;
    logic       acc_done;
    logic       factor_zero;
    logic       div_done;
    logic       out_free;
  } ltcw_stat_t;

endpackage

// File: hw/rtl/ltcw_div.sv
// ----------------------------------------------------------------------------
// ltcw_div
// Restoring divider, one quotient bit per cycle, with sign and saturation of
// the quotient to the signed result width.
// ----------------------------------------------------------------------------
module ltcw_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [ltcw_pkg::DVD_BITS-1:0]        dividend,
  input  logic [ltcw_pkg::DEN_BITS-1:0]        divisor,
  input  logic                                 neg,
  output logic                                 done,
  output logic signed [ltcw_pkg::RES_BITS-1:0] quotient
);
  import ltcw_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0]     dq;
  logic [DEN_BITS-1:0]     rem;
  logic [DEN_BITS-1:0]     den;
  logic                    neg_q;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   trial_sub;
  logic                ge;
  logic [DVD_BITS-1:0] limit;
  logic [DVD_BITS-1:0] sat;
  logic [DVD_BITS-1:0] signed_full;

  always_comb begin
    trial     = {rem, dq[DVD_BITS-1]};
    trial_sub = trial - {1'b0, den};
    ge        = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      rem   <= '0;
      den   <= divisor;
      neg_q <= neg;
    end else if (busy) begin
      rem <= ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      dq  <= {dq[DVD_BITS-2:0], ge};
    end
  end

  always_comb begin
    limit       = neg_q ? SAT_NEG : SAT_POS;
    sat         = (dq > limit) ? limit : dq;
    signed_full = neg_q ? (~sat + 1'b1) : sat;
    quotient    = signed'(signed_full[RES_BITS-1:0]);
  end

endmodule

// File: hw/rtl/ltcw_dp.sv
// ----------------------------------------------------------------------------
// ltcw_dp
// Datapath: configuration registers, tare offset and factor, averaging
// accumulator, weight product, shared serial divider and output register.
// ----------------------------------------------------------------------------
module ltcw_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ltcw_pkg::ltcw_cmd_t                   cmd,
  output ltcw_pkg::ltcw_stat_t                  stat,
  input  logic [ltcw_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input  logic [1:0]                            s_tuser,
  input  logic                                  cfg_we,
  input  logic [ltcw_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [ltcw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ltcw_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic [1:0]                            m_tuser
);
  import ltcw_pkg::*;

  logic [KW_BITS-1:0]            known_weight;
  logic [CNT_BITS-1:0]           avg_count;
  logic [1:0]                    opcode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] tare_offset;
  logic signed [RES_BITS-1:0]    factor;
  mode_t                         mode;
  logic signed [SUM_BITS-1:0]    running_sum;
  logic [CNT_BITS-1:0]           valid_count;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic [NUM_BITS-1:0]           prod;
  logic                          prod_neg;
  logic [1:0]                    res_kind;
  logic signed [RES_BITS-1:0]    res_weight;
  logic                          out_valid;
  logic [OUT_DATA_BITS-1:0]      out_data;
  logic [1:0]                    out_kind;

  logic [CNT_BITS-1:0]        n_eff;
  logic [KW_BITS-1:0]         kw_eff;
  logic [CNT_BITS-1:0]        cnt_inc;
  logic [SUM_BITS-1:0]        sum_mag;
  logic signed [DIFF_BITS-1:0] cal_diff;
  logic [DIFF_BITS-1:0]       cal_mag;
  logic signed [DIFF_BITS-1:0] wgt_diff;
  logic [DIFF_BITS-1:0]       wgt_mag;
  logic [RES_BITS-1:0]        fac_mag;
  logic [DVD_BITS-1:0]        div_dividend;
  logic [DEN_BITS-1:0]        div_divisor;
  logic                       div_neg;
  logic                       div_done;
  logic signed [RES_BITS-1:0] div_res;

  always_comb begin
    n_eff    = (avg_count == '0) ? CNT_BITS'(1) : avg_count;
    kw_eff   = (known_weight == '0) ? KW_BITS'(1) : known_weight;
    cnt_inc  = valid_count + 1'b1;
    sum_mag  = running_sum[SUM_BITS-1] ? (~running_sum + 1'b1) : running_sum;
    cal_diff = DIFF_BITS'(avg) - DIFF_BITS'(tare_offset);
    cal_mag  = cal_diff[DIFF_BITS-1] ? (~cal_diff + 1'b1) : cal_diff;
    wgt_diff = DIFF_BITS'(sample) - DIFF_BITS'(tare_offset);
    wgt_mag  = wgt_diff[DIFF_BITS-1] ? (~wgt_diff + 1'b1) : wgt_diff;
    fac_mag  = factor[RES_BITS-1] ? (~factor + 1'b1) : factor;
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_AVG: begin
        div_dividend = DVD_BITS'(sum_mag);
        div_divisor  = DEN_BITS'(n_eff);
        div_neg      = running_sum[SUM_BITS-1];
      end
      DIV_CAL: begin
        div_dividend = DVD_BITS'(cal_mag) << FRACTION_BITS;
        div_divisor  = DEN_BITS'(kw_eff);
        div_neg      = cal_diff[DIFF_BITS-1];
      end
      DIV_WGT: begin
        div_dividend = DVD_BITS'(prod) << FRACTION_BITS;
        div_divisor  = DEN_BITS'(fac_mag);
        div_neg      = prod_neg;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DEN_BITS'(1);
        div_neg      = 1'b0;
      end
    endcase
  end

  ltcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .neg      (div_neg),
    .done     (div_done),
    .quotient (div_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      known_weight <= KNOWN_WEIGHT_RESET;
      avg_count    <= AVG_COUNT_RESET;
      tare_offset  <= '0;
      factor       <= FACTOR_RESET;
      mode         <= MODE_TARE;
      running_sum  <= '0;
      valid_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_KNOWN_WEIGHT: known_weight <= cfg_data;
          REG_AVG_COUNT:    avg_count    <= cfg_data[CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.start_avg) begin
        mode        <= (opcode == OP_TARE) ? MODE_TARE : MODE_CAL;
        running_sum <= '0;
        valid_count <= '0;
      end
      if (cmd.accumulate) begin
        running_sum <= running_sum + SUM_BITS'(sample);
        valid_count <= cnt_inc;
      end
      if (cmd.clear_avg) begin
        mode        <= MODE_IDLE;
        running_sum <= '0;
        valid_count <= '0;
      end
      if (cmd.load_offset) tare_offset <= SAMPLE_BITS'(div_res);
      if (cmd.load_factor) factor <= div_res;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode <= s_tuser;
      sample <= signed'(s_tdata[SAMPLE_BITS-1:0]);
    end
    if (cmd.load_avg) avg <= SAMPLE_BITS'(div_res);
    if (cmd.mul) begin
      prod     <= NUM_BITS'(wgt_mag) * CENTI_SCALE;
      prod_neg <= wgt_diff[DIFF_BITS-1] ^ factor[RES_BITS-1];
    end
    if (cmd.set_kind) begin
      res_kind <= cmd.kind;
      if (cmd.kind != KIND_WEIGHT) res_weight <= '0;
    end
    if (cmd.load_weight) res_weight <= div_res;
    if (cmd.out_load) begin
      out_data <= OUT_DATA_BITS'({factor, tare_offset, res_weight});
      out_kind <= res_kind;
    end
  end

  always_comb begin
    stat.opcode      = opcode;
    stat.missing     = (sample == '1);
    stat.mode        = mode;
    stat.acc_done    = (cnt_inc >= n_eff);
    stat.factor_zero = (factor == '0);
    stat.div_done    = div_done;
    stat.out_free    = !out_valid || m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_kind;

endmodule

// File: hw/rtl/ltcw_ctrl.sv
// ----------------------------------------------------------------------------
// ltcw_ctrl
// Controller: sequences decode, averaging, calibration and weight division
// steps and the result transfer.
// ----------------------------------------------------------------------------
module ltcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ltcw_pkg::ltcw_stat_t stat,
  output ltcw_pkg::ltcw_cmd_t  cmd
);
  import ltcw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_AVG;
    s_tready    = 1'b0;
    case (state)
      S_IDLE: begin
        // no transfer while reset is held
        s_tready    = !rst;
        cmd.capture = s_tvalid && s_tready;
        if (s_tvalid && s_tready) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (stat.opcode == OP_TARE || stat.opcode == OP_CAL) begin
          cmd.start_avg = 1'b1;
        end else if (stat.opcode == OP_SAMPLE && !stat.missing) begin
          if (stat.mode != MODE_IDLE) begin
            cmd.accumulate = 1'b1;
            if (stat.acc_done) state_next = S_AVG_GO;
          end else if (stat.factor_zero) begin
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_ZERO;
            state_next   = S_OUT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        cmd.div_sel = DIV_AVG;
        if (stat.div_done) begin
          cmd.clear_avg = 1'b1;
          if (stat.mode == MODE_TARE) begin
            cmd.load_offset = 1'b1;
            cmd.set_kind    = 1'b1;
            cmd.kind        = KIND_TARE;
            state_next      = S_OUT;
          end else begin
            cmd.load_avg = 1'b1;
            state_next   = S_CAL_GO;
          end
        end
      end
      S_CAL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CAL;
        state_next    = S_CAL_WAIT;
      end
      S_CAL_WAIT: begin
        cmd.div_sel = DIV_CAL;
        if (stat.div_done) begin
          cmd.load_factor = 1'b1;
          cmd.set_kind    = 1'b1;
          cmd.kind        = KIND_CAL;
          state_next      = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_WGT_GO;
      end
      S_WGT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WGT;
        state_next    = S_WGT_WAIT;
      end
      S_WGT_WAIT: begin
        cmd.div_sel = DIV_WGT;
        if (stat.div_done) begin
          cmd.load_weight = 1'b1;
          cmd.set_kind    = 1'b1;
          cmd.kind        = KIND_WEIGHT;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        // wait until the previous result transfer has gone
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/load_cell_tare_calibrate_weigher.sv
// Items are taken one at a time: the input is not ready again until the last
// item is through. The bit-serial divider sets the pace of weight, tare and
// calibration results, and a result waits until the output is free; items
// with no result (commands, averaged or missing samples) only pass decode.
// Reset (rst, synchronous) restores register defaults and starts a tare.
// ----------------------------------------------------------------------------
// load_cell_tare_calibrate_weigher
// Load cell front end: tare and span calibration by averaging, and weight in
// hundredths of a gram for each sample outside an averaging run.
// ----------------------------------------------------------------------------
module load_cell_tare_calibrate_weigher (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ltcw_pkg::IN_DATA_BITS-1:0]  s_tdata,   // sample
  input  logic [1:0]                         s_tuser,   // opcode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // weight_centigrams, offset_value, factor_q16
  output logic [ltcw_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic [1:0]                         m_tuser,   // kind
  input  logic                               cfg_we,
  input  logic [ltcw_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [ltcw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ltcw_pkg::*;

  ltcw_cmd_t  cmd;
  ltcw_stat_t stat;

  ltcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ltcw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sim/load_cell_tare_calibrate_weigher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_tare_calibrate_weigher_tb
// Drives samples, tare and calibrate commands through the stream input, with
// random gaps and back-pressure, and checks every result against a cycle-free
// model of offset, factor and weight. It walks through several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module load_cell_tare_calibrate_weigher_tb;
  import ltcw_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 150;
  localparam int          RANDOM_ITEMS   = 1500;
  localparam int          MAX_REPORTS    = 100;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [23:0] MISSING        = 24'hFFFFFF;
  localparam logic [15:0] KW_DEFAULT     = 16'd796;
  localparam logic [7:0]  COUNT_DEFAULT  = 8'd20;
  // 74.17 counts per gram in Q16.16
  localparam logic [31:0] FACTOR_DEFAULT = 32'((64'd7417 << 16) / 64'd100);

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] weight;
    logic signed [23:0] offset;
    logic signed [31:0] factor;
  } weigh_result_t;

  class weigher_scoreboard;
    logic [15:0]        known_weight;
    logic [7:0]         avg_count;
    logic signed [23:0] offset;
    logic signed [31:0] factor;
    mode_t              mode;
    longint             sum;
    logic [7:0]         taken;
    weigh_result_t      results_due[$];
    int                 errors;

    function new();
      known_weight = KW_DEFAULT;
      avg_count    = COUNT_DEFAULT;
      offset       = '0;
      factor       = FACTOR_DEFAULT;
      mode         = MODE_TARE;
      sum          = 0;
      taken        = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [CFG_ADDR_BITS-1:0] idx, logic [15:0] val);
      if (idx == REG_KNOWN_WEIGHT) known_weight = val;
      else avg_count = val[7:0];
    endfunction

    function longint unsigned magnitude_of(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // (num << 16) / den truncated, signed, clamped to 32 bits
    function longint q16_ratio(longint unsigned num, bit neg, longint unsigned den);
      longint unsigned lim, hi, rem, q;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      hi  = num / den;
      rem = num % den;
      if ((hi >> 32) != 0) begin
        q = lim;
      end else begin
        q = (hi << 16) + ((rem << 16) / den);
        if (q > lim) q = lim;
      end
      return neg ? -$signed(q) : $signed(q);
    endfunction

    function void note_transfer(logic [1:0] op, logic [23:0] raw);
      weigh_result_t   r;
      longint          s, avg, diff, n, q;
      longint unsigned kw;
      bit              neg;
      if (op == OP_TARE || op == OP_CAL) begin
        mode  = (op == OP_TARE) ? MODE_TARE : MODE_CAL;
        sum   = 0;
        taken = '0;
        return;
      end
      if (op != OP_SAMPLE) return;
      s = $signed(raw);
      if (s == -1) return;
      r.weight = '0;
      if (mode != MODE_IDLE) begin
        n     = (avg_count == 0) ? 1 : avg_count;
        sum   = sum + s;
        taken = taken + 8'd1;
        if (taken < n) return;
        avg = sum / n;
        if (mode == MODE_TARE) begin
          offset = 24'(avg);
          r.kind = KIND_TARE;
        end else begin
          diff   = avg - offset;
          kw     = (known_weight == 0) ? 1 : known_weight;
          q      = q16_ratio(magnitude_of(diff), diff < 0, kw);
          factor = 32'(q);
          r.kind = KIND_CAL;
        end
        mode  = MODE_IDLE;
        sum   = 0;
        taken = '0;
      end else if (factor == 0) begin
        r.kind = KIND_ZERO;
      end else begin
        diff     = s - offset;
        neg      = (diff < 0) != (factor < 0);
        q        = q16_ratio(magnitude_of(diff) * 100, neg, magnitude_of(factor));
        r.weight = 32'(q);
        r.kind   = KIND_WEIGHT;
      end
      r.offset = offset;
      r.factor = factor;
      results_due.push_back(r);
    endfunction

    function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [OUT_DATA_BITS-1:0] data);
      weigh_result_t due;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result with none due, expected nothing, actual kind %0d",
                   $time, kind);
        return;
      end
      due = results_due.pop_front();
      compare("kind", due.kind, kind);
      compare("weight", due.weight, $signed(data[RES_BITS-1:0]));
      compare("offset", due.offset, $signed(data[RES_BITS +: SAMPLE_BITS]));
      compare("factor", due.factor, $signed(data[RES_BITS+SAMPLE_BITS +: RES_BITS]));
    endfunction
  endclass

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
  logic [1:0]               s_tuser  = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [1:0]               m_tuser;
  logic                     cfg_we   = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  weigher_scoreboard sb = new();
  bit steady = 1'b0;
  int sent   = 0;
  int quiet  = 0;

  load_cell_tare_calibrate_weigher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check, random back-pressure, watchdog on cycles without a transfer
  always @(posedge clk) begin
    if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tuser, m_tdata);
    m_tready <= steady || ($urandom_range(99) >= 26);
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [23:0] raw);
    if (!steady && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= raw;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_transfer(op, raw);
    if (op != OP_UNUSED && !(op == OP_SAMPLE && raw == MISSING)) sent++;
  endtask

  // hold the input until every due result is out, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] kw, input logic [7:0] count);
    logic [15:0] count_word;
    count_word = {8'($urandom), count};
    drain_results();
    cfg_we   <= 1'b1;
    cfg_addr <= REG_KNOWN_WEIGHT;
    cfg_data <= kw;
    @(posedge clk);
    sb.set_register(REG_KNOWN_WEIGHT, kw);
    cfg_addr <= REG_AVG_COUNT;
    cfg_data <= count_word;
    @(posedge clk);
    sb.set_register(REG_AVG_COUNT, count_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] jitter(int base, int spread);
    return 24'(base + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [23:0] pick_sample();
    logic [23:0] corners [5] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFE};
    case ($urandom_range(9))
      0, 1, 2: return 24'($urandom);
      3:       return corners[$urandom_range(4)];
      default: return jitter(sb.offset, 1 << $urandom_range(20, 4));
    endcase
  endfunction

  task automatic run_episode();
    int n, len, base;
    n   = (sb.avg_count == 0) ? 1 : int'(sb.avg_count);
    // now and then an averaging run is sent with fewer samples than the count
    len = ($urandom_range(7) == 0) ? int'($urandom_range(n - 1)) : n;
    case ($urandom_range(9))
      0: begin
        base = $urandom_range(1) ? int'($urandom) : int'($urandom_range(400000)) - 200000;
        send_item(OP_TARE, 24'($urandom));
        repeat (len) send_item(OP_SAMPLE, jitter(base, 64));
      end
      1, 2: begin
        base = sb.offset + (int'($urandom_range(1)) * 2 - 1)
             * int'($urandom_range(1 << $urandom_range(22), 1));
        send_item(OP_CAL, 24'($urandom));
        repeat (len) send_item(OP_SAMPLE, jitter(base, 16));
      end
      3: begin
        repeat ($urandom_range(6, 1))
          send_item(2'($urandom), ($urandom_range(3) == 0) ? MISSING : 24'($urandom));
      end
      default: begin
        repeat ($urandom_range(12, 3))
          send_item(OP_SAMPLE, ($urandom_range(15) == 0) ? MISSING : pick_sample());
      end
    endcase
  endtask

  initial begin
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // startup tare: ignored items first, then extremes whose mean truncates to zero
    send_item(OP_SAMPLE, MISSING);
    send_item(OP_UNUSED, 24'h5A5A5A);
    for (int i = 0; i < 20; i++) send_item(OP_SAMPLE, i[0] ? 24'h7FFFFF : 24'h800000);
    send_item(OP_SAMPLE, 24'h7FFFFF);
    send_item(OP_SAMPLE, 24'h800000);
    send_item(OP_SAMPLE, 24'h000000);

    configure(16'd1, 8'd1);
    send_item(OP_CAL, 24'h0);
    send_item(OP_SAMPLE, 24'h7FFFFF);
    send_item(OP_SAMPLE, 24'h800000);
    send_item(OP_CAL, 24'h0);
    send_item(OP_SAMPLE, 24'h800000);
    send_item(OP_SAMPLE, 24'h7FFFFF);
    // calibrate at the offset itself: factor becomes zero
    send_item(OP_CAL, 24'h0);
    send_item(OP_SAMPLE, sb.offset);
    send_item(OP_SAMPLE, 24'h000123);

    // count zero acts as one; a one-lsb factor drives the weight into clamping
    configure(16'hFFFF, 8'd0);
    send_item(OP_TARE, 24'h0);
    send_item(OP_SAMPLE, 24'd100);
    send_item(OP_CAL, 24'h0);
    send_item(OP_SAMPLE, 24'd101);
    send_item(OP_SAMPLE, 24'h800000);
    send_item(OP_SAMPLE, 24'h7FFFFF);

    // reference weight zero, a command restarting a run, then the count lowered mid-run
    configure(16'd0, 8'd4);
    send_item(OP_TARE, 24'h0);
    send_item(OP_SAMPLE, 24'd7);
    send_item(OP_SAMPLE, 24'd9);
    send_item(OP_CAL, 24'h0);
    repeat (3) send_item(OP_SAMPLE, 24'd40000);
    configure(16'd0, 8'd2);
    send_item(OP_SAMPLE, 24'd40004);
    send_item(OP_SAMPLE, 24'd5000);

    start = sent;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       configure(KW_DEFAULT, COUNT_DEFAULT);
        1:       configure(16'd1, 8'd1);
        2:       configure(16'hFFFF, 8'hFF);
        3:       configure(16'd0, 8'd0);
        default: configure(16'($urandom_range(65535, 1)), 8'($urandom_range(6, 1)));
      endcase
      steady = (p == 5);
      while (sent < start + (p + 1) * RANDOM_ITEMS / 8) run_episode();
    end
    steady = 1'b0;

    drain_results();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
